/* rtl/shs_pkg.sv */
package shs_pkg;

	localparam int CountW = 61;

	// controller to datapath commands
	typedef struct packed {
		logic write_byte;
		logic pad;
		logic len;
		logic clear;
		logic load;
		logic round;
		logic add;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [5:0] pos;
		logic       round_last;
		logic       out_busy;
	} stat_t;

	// initial hash values
	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	// round constants
	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] r;
		case (idx)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	// big-endian byte insert: keep earlier bytes, set this one, clear later ones
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
		input logic [7:0] b);
		logic [31:0] r;
		r = w;
		for (int k = 0; k < 4; k++) begin
			if (2'(k) == lane) begin
				r[31-8*k -: 8] = b;
			end else if (2'(k) > lane) begin
				r[31-8*k -: 8] = 8'h00;
			end
		end
		return r;
	endfunction

endpackage

/* rtl/shs_ctrl.sv */
module shs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            byte_valid,
	input  logic            last,
	input  shs_pkg::stat_t  stat,
	output shs_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_LEN   = 3'd2;
	localparam logic [2:0] S_LOAD  = 3'd3;
	localparam logic [2:0] S_ROUND = 3'd4;
	localparam logic [2:0] S_ADD   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	// what follows a compression
	localparam logic [1:0] PH_DATA  = 2'd0;
	localparam logic [1:0] PH_PAD1  = 2'd1;
	localparam logic [1:0] PH_FINAL = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       fin_q, fin_d;
	logic       take;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid & in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		fin_d   = fin_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd.write_byte = byte_valid;
					fin_d = last;
					if (byte_valid && stat.pos == 6'd63) begin
						phase_d = PH_DATA;
						state_d = S_LOAD;
					end else if (last) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.pad = 1'b1;
				if (stat.pos >= 6'd56) begin
					phase_d = PH_PAD1;
				end else begin
					cmd.len = 1'b1;
					phase_d = PH_FINAL;
				end
				state_d = S_LOAD;
			end
			S_LEN: begin
				cmd.clear = 1'b1;
				cmd.len   = 1'b1;
				phase_d   = PH_FINAL;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (stat.round_last) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				case (phase_q)
					PH_PAD1:  state_d = S_LEN;
					PH_FINAL: state_d = S_OUT;
					default:  state_d = fin_q ? S_PAD : S_IDLE;
				endcase
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_DATA;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			fin_q   <= fin_d;
		end
	end

endmodule

/* rtl/shs_datapath.sv */
module shs_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  shs_pkg::cmd_t   cmd,
	output shs_pkg::stat_t  stat,
	input  logic [7:0]      data_byte,
	output logic [31:0]     digest_word,
	output logic [2:0]      word_index,
	output logic            last_word,
	output logic            out_valid,
	input  logic            out_ready
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] hash_q [8];
	logic [31:0] ob_q [8];
	logic [31:0] kw_q;
	logic [shs_pkg::CountW-1:0] count_q;
	logic [5:0]  rnd_q;
	logic [2:0]  ob_idx_q;
	logic        ob_valid_q;

	logic [5:0]  pos;
	logic [3:0]  widx;
	logic [1:0]  lane;
	logic [63:0] bit_len;
	logic [31:0] w_new;
	logic [31:0] t1, t2;
	logic        out_take;

	assign pos     = count_q[5:0];
	assign widx    = pos[5:2];
	assign lane    = pos[1:0];
	assign bit_len = {count_q, 3'b000};
	assign out_take = ob_valid_q & out_ready;

	assign stat.pos        = pos;
	assign stat.round_last = (rnd_q == 6'd63);
	assign stat.out_busy   = ob_valid_q;

	// message schedule: next word entering the window
	assign w_new = shs_pkg::small_sigma1(w_q[14]) + w_q[9]
		+ shs_pkg::small_sigma0(w_q[1]) + w_q[0];

	// round function
	assign t1 = v_q[7] + shs_pkg::big_sigma1(v_q[4])
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + kw_q;
	assign t2 = shs_pkg::big_sigma0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// block buffer, doubles as the schedule window during rounds
	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++) begin
			if (cmd.len && i == 14) begin
				w_q[i] <= bit_len[63:32];
			end else if (cmd.len && i == 15) begin
				w_q[i] <= bit_len[31:0];
			end else if (cmd.clear) begin
				w_q[i] <= 32'h0;
			end else if (cmd.round) begin
				w_q[i] <= (i == 15) ? w_new : w_q[(i + 1) % 16];
			end else if (cmd.write_byte && 4'(i) == widx) begin
				w_q[i] <= shs_pkg::put_byte(w_q[i], lane, data_byte);
			end else if (cmd.pad && 4'(i) == widx) begin
				w_q[i] <= shs_pkg::put_byte(w_q[i], lane, 8'h80);
			end else if (cmd.pad && 4'(i) > widx) begin
				w_q[i] <= 32'h0;
			end
		end
	end

	// working variables and precomputed k plus w
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
			kw_q <= shs_pkg::round_k(6'd0) + w_q[0];
		end else if (cmd.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			kw_q <= shs_pkg::round_k(6'(rnd_q + 6'd1)) + w_q[1];
		end
	end

	// chaining hash, byte count and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= shs_pkg::init_hash(3'(i));
			end
			count_q <= '0;
			rnd_q   <= 6'd0;
		end else begin
			if (cmd.add) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end else if (cmd.emit) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= shs_pkg::init_hash(3'(i));
				end
			end
			if (cmd.emit) begin
				count_q <= '0;
			end else if (cmd.write_byte) begin
				count_q <= count_q + shs_pkg::CountW'(1);
			end
			if (cmd.load) begin
				rnd_q <= 6'd0;
			end else if (cmd.round) begin
				rnd_q <= 6'(rnd_q + 6'd1);
			end
		end
	end

	// digest output buffer
	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			if (cmd.emit) begin
				ob_q[i] <= hash_q[i];
			end else if (out_take) begin
				ob_q[i] <= (i == 7) ? ob_q[i] : ob_q[(i + 1) % 8];
			end
		end
	end

	// output transaction tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			ob_idx_q   <= 3'd0;
		end else if (cmd.emit) begin
			ob_valid_q <= 1'b1;
			ob_idx_q   <= 3'd0;
		end else if (out_take) begin
			ob_idx_q <= 3'(ob_idx_q + 3'd1);
			if (ob_idx_q == 3'd7) begin
				ob_valid_q <= 1'b0;
			end
		end
	end

	assign digest_word = ob_q[0];
	assign word_index  = ob_idx_q;
	assign last_word   = (ob_idx_q == 3'd7);
	assign out_valid   = ob_valid_q;

endmodule

/* rtl/sha256_stream_hasher_unit.sv */
// a byte is accepted whenever the unit is idle; the 64th byte of a block starts a compression
// (load, 64 rounds of the single round unit, feed-forward add)
// a last transaction adds padding (marker, then length, in a further block if it does not fit)
// plus one or two compressions, then the digest moves into the output buffer (waiting while it still drains)
// the eight digest words leave one per cycle from the output buffer as the sink takes them
// asynchronous reset loads the initial hash values and clears count and control state
module sha256_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	shs_pkg::cmd_t  cmd;
	shs_pkg::stat_t stat;

	// sequencing
	shs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_valid (byte_valid),
		.last       (last),
		.stat       (stat),
		.cmd        (cmd)
	);

	// block buffer, rounds and digest output
	shs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.data_byte   (data_byte),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule
